FILE: hdl/aabb_pkg.sv
// Package for the box transform pipeline: register indexes, fixed formats
// and the clamp helper for wide products. Used by every file of the block.
`default_nettype none

package aabb_pkg;

    localparam int AXES = 3;
    localparam int ALIGN_FRAC = 16;
    localparam int EXT_EPS = 6;
    localparam int WIDE_LIM_LOG = 56;
    localparam int WIDE_W = WIDE_LIM_LOG + 2;
    localparam int XW = 128;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFZ = 3'd5;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam logic signed [XW-1:0] WIDE_LIM = XW'(128'sd1 <<< WIDE_LIM_LOG);

    function automatic t_wide clamp_wide(input logic signed [XW-1:0] v);
        t_wide res;
        if (v > WIDE_LIM) begin
            res = WIDE_LIM[WIDE_W-1:0];
        end else if (v < -WIDE_LIM) begin
            res = t_wide'(-WIDE_LIM);
        end else begin
            res = v[WIDE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/aabb_affine_transform.sv
// Top level of the box transform pipeline: products, sums, corners and a
// bit-per-stage divider for the alignment. Depends on aabb_pkg.
//
//  channel   direction  handshake                   payload
//  request   in         i_req_valid / o_req_ready    i_box_valid, corners, alignments
//  result    out        o_res_valid / i_res_ready    o_out_valid, corners, alignments
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One box enters per cycle while the request side is ready; each passes the fixed
// stages and the one-bit-per-stage restoring divider before the output register.
// Reset clears the stage valid bits and loads the identity transform.
// A stage moves on when it is empty or the next one moves on, so a stall
// fills bubbles and never drops or repeats a beat.
`default_nettype none

module aabb_affine_transform
    import aabb_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEFF_WIDTH = 16,
    localparam int CFG_W = (3 * COEFF_WIDTH > COORD_WIDTH) ? 3 * COEFF_WIDTH : COORD_WIDTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    output logic                         o_req_ready,
    input  wire                          i_box_valid,
    input  wire signed [COORD_WIDTH-1:0] i_in_lower_x,
    input  wire signed [COORD_WIDTH-1:0] i_in_lower_y,
    input  wire signed [COORD_WIDTH-1:0] i_in_lower_z,
    input  wire signed [COORD_WIDTH-1:0] i_in_upper_x,
    input  wire signed [COORD_WIDTH-1:0] i_in_upper_y,
    input  wire signed [COORD_WIDTH-1:0] i_in_upper_z,
    input  wire signed [COORD_WIDTH-1:0] i_in_align_x,
    input  wire signed [COORD_WIDTH-1:0] i_in_align_y,
    input  wire signed [COORD_WIDTH-1:0] i_in_align_z,
    output logic                         o_res_valid,
    input  wire                          i_res_ready,
    output logic                         o_out_valid,
    output logic signed [COORD_WIDTH-1:0] o_out_lower_x,
    output logic signed [COORD_WIDTH-1:0] o_out_lower_y,
    output logic signed [COORD_WIDTH-1:0] o_out_lower_z,
    output logic signed [COORD_WIDTH-1:0] o_out_upper_x,
    output logic signed [COORD_WIDTH-1:0] o_out_upper_y,
    output logic signed [COORD_WIDTH-1:0] o_out_upper_z,
    output logic signed [COORD_WIDTH-1:0] o_out_align_x,
    output logic signed [COORD_WIDTH-1:0] o_out_align_y,
    output logic signed [COORD_WIDTH-1:0] o_out_align_z,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [CFG_W-1:0]              i_cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int KW = COEFF_WIDTH;
    localparam int KF = KW - 4;
    localparam int RW = 3 * KW;
    localparam int EW = CW + 1;
    localparam int PA_W = CW + EW;
    localparam int PS_W = KW + EW;
    localparam int OW = WIDE_W + 1;
    localparam int PO_W = KW + OW;
    localparam int SW = WIDE_W + 3;
    localparam int NW = WIDE_W + 1;
    localparam int HW = SW + 1;
    localparam int UW = HW + 1;
    localparam int DW = UW + ALIGN_FRAC;
    localparam int DS = CW - 1;
    localparam int NFIX = 6;

    localparam logic signed [HW-1:0] CMAX_H = $signed({{(HW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [HW-1:0] CMIN_H = -CMAX_H - HW'(1);
    localparam logic [CW-1:0] CMAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN_C = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [NW-1:0]   rem;
        logic [CW-2:0]   dlo;
        logic [CW-2:0]   quo;
        logic [NW-1:0]   den;
        logic            neg;
        logic            ovf;
        logic            flat;
        logic            bv;
        logic [CW-1:0]   lw;
        logic [CW-1:0]   uw;
        logic [CW-1:0]   al;
    } t_div_lane;

    typedef t_div_lane [AXES-1:0] t_div;

    function automatic logic [CW-1:0] sat_c(input logic signed [HW-1:0] v);
        logic [CW-1:0] res;
        if (v > CMAX_H) begin
            res = CMAX_C;
        end else if (v < CMIN_H) begin
            res = CMIN_C;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    // Configuration.
    logic [RW-1:0] r_row [AXES];
    t_coord        r_off [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < AXES; r++) begin
                r_row[r] <= RW'(1) << (r * KW + KF);
                r_off[r] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW0: r_row[0] <= i_cfg_data[RW-1:0];
                CFG_ROW1: r_row[1] <= i_cfg_data[RW-1:0];
                CFG_ROW2: r_row[2] <= i_cfg_data[RW-1:0];
                CFG_OFFX: r_off[0] <= i_cfg_data[CW-1:0];
                CFG_OFFY: r_off[1] <= i_cfg_data[CW-1:0];
                CFG_OFFZ: r_off[2] <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic signed [KW-1:0] coef [AXES][AXES];

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            for (int j = 0; j < AXES; j++) begin
                coef[r][j] = $signed(r_row[r][j*KW +: KW]);
            end
        end
    end

    // Stage control.
    logic [NFIX-1:0] r_v;
    logic [NFIX-1:0] en_f;
    logic [DS-1:0]   r_dv_v;
    logic [DS-1:0]   en_dv;
    logic            r_out_v;
    logic            en_out;

    assign en_out = !r_out_v || i_res_ready;

    always_comb begin
        en_dv[DS-1] = !r_dv_v[DS-1] || en_out;
        for (int k = DS - 2; k >= 0; k--) begin
            en_dv[k] = !r_dv_v[k] || en_dv[k+1];
        end
        en_f[NFIX-1] = !r_v[NFIX-1] || en_dv[0];
        for (int k = NFIX - 2; k >= 0; k--) begin
            en_f[k] = !r_v[k] || en_f[k+1];
        end
    end

    assign o_req_ready = en_f[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_dv_v  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (en_f[0]) begin
                r_v[0] <= i_req_valid;
            end
            for (int k = 1; k < NFIX; k++) begin
                if (en_f[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (en_dv[0]) begin
                r_dv_v[0] <= r_v[NFIX-1];
            end
            for (int k = 1; k < DS; k++) begin
                if (en_dv[k]) begin
                    r_dv_v[k] <= r_dv_v[k-1];
                end
            end
            if (en_out) begin
                r_out_v <= r_dv_v[DS-1];
            end
        end
    end

    // Stage 1: extents and doubled centers.
    t_coord               in_lo [AXES];
    t_coord               in_up [AXES];
    t_coord               in_al [AXES];
    logic                 r1_bv;
    t_coord               r1_lo [AXES];
    t_coord               r1_up [AXES];
    t_coord               r1_al [AXES];
    logic signed [EW-1:0] r1_e [AXES];
    logic signed [EW-1:0] r1_s [AXES];

    assign in_lo[0] = i_in_lower_x;
    assign in_lo[1] = i_in_lower_y;
    assign in_lo[2] = i_in_lower_z;
    assign in_up[0] = i_in_upper_x;
    assign in_up[1] = i_in_upper_y;
    assign in_up[2] = i_in_upper_z;
    assign in_al[0] = i_in_align_x;
    assign in_al[1] = i_in_align_y;
    assign in_al[2] = i_in_align_z;

    always_ff @(posedge i_clk) begin
        if (en_f[0]) begin
            r1_bv <= i_box_valid;
            for (int j = 0; j < AXES; j++) begin
                r1_lo[j] <= in_lo[j];
                r1_up[j] <= in_up[j];
                r1_al[j] <= in_al[j];
                r1_e[j]  <= EW'(in_up[j]) - EW'(in_lo[j]);
                r1_s[j]  <= EW'(in_up[j]) + EW'(in_lo[j]);
            end
        end
    end

    // Stage 2: alignment offsets and coefficient products.
    logic signed [PA_W-1:0] t_pa [AXES];
    logic signed [PS_W-1:0] t_ps [AXES][AXES];
    logic signed [PS_W-1:0] t_pe [AXES][AXES];
    logic                   r2_bv;
    t_coord                 r2_lo [AXES];
    t_coord                 r2_up [AXES];
    t_coord                 r2_al [AXES];
    t_wide                  r2_pa [AXES];
    t_wide                  r2_ps [AXES][AXES];
    t_wide                  r2_pe [AXES][AXES];

    always_comb begin
        for (int j = 0; j < AXES; j++) begin
            t_pa[j] = PA_W'(r1_al[j]) * PA_W'(r1_e[j]);
        end
        for (int r = 0; r < AXES; r++) begin
            for (int j = 0; j < AXES; j++) begin
                t_ps[r][j] = PS_W'(coef[r][j]) * PS_W'(r1_s[j]);
                t_pe[r][j] = PS_W'(coef[r][j]) * PS_W'(r1_e[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f[1]) begin
            r2_bv <= r1_bv;
            for (int j = 0; j < AXES; j++) begin
                r2_lo[j] <= r1_lo[j];
                r2_up[j] <= r1_up[j];
                r2_al[j] <= r1_al[j];
                r2_pa[j] <= clamp_wide(XW'(t_pa[j] >>> ALIGN_FRAC));
            end
            for (int r = 0; r < AXES; r++) begin
                for (int j = 0; j < AXES; j++) begin
                    r2_ps[r][j] <= clamp_wide(XW'(t_ps[r][j] >>> KF));
                    r2_pe[r][j] <= clamp_wide(XW'(t_pe[r][j] >>> KF));
                end
            end
        end
    end

    // Stage 3: origins, doubled new centers and new extents.
    logic signed [SW-1:0]   n3_c [AXES];
    logic [NW-1:0]          n3_n [AXES];
    logic                   r3_bv;
    t_coord                 r3_lo [AXES];
    t_coord                 r3_up [AXES];
    t_coord                 r3_al [AXES];
    logic signed [OW-1:0]   r3_org [AXES];
    logic signed [SW-1:0]   r3_c [AXES];
    logic [NW-1:0]          r3_n [AXES];

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            n3_c[r] = SW'(r_off[r]) <<< 1;
            n3_n[r] = '0;
            for (int j = 0; j < AXES; j++) begin
                n3_c[r] = n3_c[r] + SW'(r2_ps[r][j]);
                n3_n[r] = n3_n[r] + NW'(r2_pe[r][j] < 0 ? -r2_pe[r][j] : r2_pe[r][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f[2]) begin
            r3_bv <= r2_bv;
            for (int j = 0; j < AXES; j++) begin
                r3_lo[j]  <= r2_lo[j];
                r3_up[j]  <= r2_up[j];
                r3_al[j]  <= r2_al[j];
                r3_org[j] <= OW'(r2_lo[j]) + OW'(r2_pa[j]);
                r3_c[j]   <= n3_c[j];
                r3_n[j]   <= n3_n[j];
            end
        end
    end

    // Stage 4: origin products.
    logic signed [PO_W-1:0] t_po [AXES][AXES];
    logic                   r4_bv;
    t_coord                 r4_lo [AXES];
    t_coord                 r4_up [AXES];
    t_coord                 r4_al [AXES];
    logic signed [SW-1:0]   r4_c [AXES];
    logic [NW-1:0]          r4_n [AXES];
    t_wide                  r4_po [AXES][AXES];

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            for (int j = 0; j < AXES; j++) begin
                t_po[r][j] = PO_W'(coef[r][j]) * PO_W'(r3_org[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f[3]) begin
            r4_bv <= r3_bv;
            for (int r = 0; r < AXES; r++) begin
                r4_lo[r] <= r3_lo[r];
                r4_up[r] <= r3_up[r];
                r4_al[r] <= r3_al[r];
                r4_c[r]  <= r3_c[r];
                r4_n[r]  <= r3_n[r];
                for (int j = 0; j < AXES; j++) begin
                    r4_po[r][j] <= clamp_wide(XW'(t_po[r][j] >>> KF));
                end
            end
        end
    end

    // Stage 5: new corners and the alignment numerator.
    logic signed [SW-1:0] n5_o [AXES];
    logic signed [HW-1:0] n5_lo2 [AXES];
    logic signed [HW-1:0] n5_up2 [AXES];
    logic signed [HW-1:0] n5_lw [AXES];
    logic signed [HW-1:0] n5_uw [AXES];
    logic                 r5_bv;
    logic [CW-1:0]        r5_lw [AXES];
    logic [CW-1:0]        r5_uw [AXES];
    t_coord               r5_al [AXES];
    logic signed [UW-1:0] r5_num [AXES];
    logic [NW-1:0]        r5_n [AXES];
    logic                 r5_flat [AXES];

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            n5_o[r] = SW'(r_off[r]);
            for (int j = 0; j < AXES; j++) begin
                n5_o[r] = n5_o[r] + SW'(r4_po[r][j]);
            end
            n5_lo2[r] = HW'(r4_c[r]) - HW'($signed({1'b0, r4_n[r]}));
            n5_up2[r] = HW'(r4_c[r]) + HW'($signed({1'b0, r4_n[r]}));
            n5_lw[r]  = n5_lo2[r] >>> 1;
            n5_uw[r]  = n5_up2[r] >>> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f[4]) begin
            r5_bv <= r4_bv;
            for (int r = 0; r < AXES; r++) begin
                r5_lw[r]   <= r4_bv ? sat_c(n5_lw[r]) : r4_lo[r];
                r5_uw[r]   <= r4_bv ? sat_c(n5_uw[r]) : r4_up[r];
                r5_al[r]   <= r4_al[r];
                r5_num[r]  <= UW'(n5_o[r]) - UW'(n5_lw[r]);
                r5_n[r]    <= r4_n[r];
                r5_flat[r] <= !r4_bv || (r4_n[r] <= NW'(EXT_EPS));
            end
        end
    end

    // Stage 6: magnitude, overflow test and first remainder.
    logic [UW-1:0]    n6_un [AXES];
    logic [DW-1:0]    n6_d [AXES];
    logic [DW+NW-1:0] n6_r0 [AXES];
    t_div             r_d6;

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            n6_un[r] = r5_num[r] < 0 ? UW'(-r5_num[r]) : UW'(r5_num[r]);
            n6_d[r]  = {n6_un[r], {ALIGN_FRAC{1'b0}}};
            n6_r0[r] = (DW + NW)'(n6_d[r] >> (CW - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f[5]) begin
            for (int r = 0; r < AXES; r++) begin
                r_d6[r].rem  <= n6_r0[r][NW-1:0];
                r_d6[r].dlo  <= n6_d[r][CW-2:0];
                r_d6[r].quo  <= '0;
                r_d6[r].den  <= r5_n[r];
                r_d6[r].neg  <= r5_num[r] < 0;
                r_d6[r].ovf  <= n6_r0[r] >= (DW + NW)'(r5_n[r]);
                r_d6[r].flat <= r5_flat[r];
                r_d6[r].bv   <= r5_bv;
                r_d6[r].lw   <= r5_lw[r];
                r_d6[r].uw   <= r5_uw[r];
                r_d6[r].al   <= r5_al[r];
            end
        end
    end

    // Divider: one quotient bit per stage.
    t_div          r_dv [DS];
    t_div          n_dv [DS];
    t_div          dv_src [DS];
    logic [NW:0]   dv_trial [DS][AXES];

    always_comb begin
        for (int k = 0; k < DS; k++) begin
            dv_src[k] = (k == 0) ? r_d6 : r_dv[(k == 0) ? 0 : k - 1];
            n_dv[k] = dv_src[k];
            for (int r = 0; r < AXES; r++) begin
                dv_trial[k][r] = {dv_src[k][r].rem, dv_src[k][r].dlo[CW-2]};
                n_dv[k][r].dlo = dv_src[k][r].dlo << 1;
                if (dv_trial[k][r] >= {1'b0, dv_src[k][r].den}) begin
                    n_dv[k][r].rem = NW'(dv_trial[k][r] - {1'b0, dv_src[k][r].den});
                    n_dv[k][r].quo = {dv_src[k][r].quo[CW-3:0], 1'b1};
                end else begin
                    n_dv[k][r].rem = dv_trial[k][r][NW-1:0];
                    n_dv[k][r].quo = {dv_src[k][r].quo[CW-3:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DS; k++) begin
            if (en_dv[k]) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // Output register.
    t_div_lane     fin [AXES];
    logic [CW-1:0] n_align [AXES];
    logic          r_out_bv;
    logic [CW-1:0] r_out_lw [AXES];
    logic [CW-1:0] r_out_uw [AXES];
    logic [CW-1:0] r_out_al [AXES];

    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            fin[r] = r_dv[DS-1][r];
            if (fin[r].flat) begin
                n_align[r] = fin[r].al;
            end else if (fin[r].ovf) begin
                n_align[r] = fin[r].neg ? CMIN_C : CMAX_C;
            end else if (fin[r].neg) begin
                n_align[r] = -CW'(fin[r].quo);
            end else begin
                n_align[r] = CW'(fin[r].quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_bv <= fin[0].bv;
            for (int r = 0; r < AXES; r++) begin
                r_out_lw[r] <= fin[r].lw;
                r_out_uw[r] <= fin[r].uw;
                r_out_al[r] <= n_align[r];
            end
        end
    end

    assign o_res_valid   = r_out_v;
    assign o_out_valid   = r_out_bv;
    assign o_out_lower_x = r_out_lw[0];
    assign o_out_lower_y = r_out_lw[1];
    assign o_out_lower_z = r_out_lw[2];
    assign o_out_upper_x = r_out_uw[0];
    assign o_out_upper_y = r_out_uw[1];
    assign o_out_upper_z = r_out_uw[2];
    assign o_out_align_x = r_out_al[0];
    assign o_out_align_y = r_out_al[1];
    assign o_out_align_z = r_out_al[2];

endmodule

`default_nettype wire

FILE: hdl/aabb_checker.sv
// Port-level checks for the box transform pipeline and the bind that
// attaches them to aabb_affine_transform. Depends on aabb_pkg.
`default_nettype none

module aabb_checker
    import aabb_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_req_ready,
    input wire                   o_res_valid,
    input wire                   i_res_ready,
    input wire                   o_out_valid,
    input wire [COORD_WIDTH-1:0] o_out_lower_x,
    input wire [COORD_WIDTH-1:0] o_out_lower_y,
    input wire [COORD_WIDTH-1:0] o_out_lower_z,
    input wire [COORD_WIDTH-1:0] o_out_upper_x,
    input wire [COORD_WIDTH-1:0] o_out_upper_y,
    input wire [COORD_WIDTH-1:0] o_out_upper_z
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result beat shown right after reset");

    // A free result side never stalls the request side.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_ready |-> o_req_ready)
        else $error("request side stalled while result side is ready");

    // A stalled result beat holds its valid and its x corners.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_out_lower_x)
            && $stable(o_out_upper_x))
        else $error("stalled result beat changed");

    // A transformed box is never inverted.
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_out_valid |->
            $signed(o_out_lower_x) <= $signed(o_out_upper_x)
            && $signed(o_out_lower_y) <= $signed(o_out_upper_y)
            && $signed(o_out_lower_z) <= $signed(o_out_upper_z))
        else $error("transformed box has lower corner above upper corner");

endmodule

bind aabb_affine_transform aabb_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_aabb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_req_ready  (o_req_ready),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_out_valid  (o_out_valid),
    .o_out_lower_x(o_out_lower_x),
    .o_out_lower_y(o_out_lower_y),
    .o_out_lower_z(o_out_lower_z),
    .o_out_upper_x(o_out_upper_x),
    .o_out_upper_y(o_out_upper_y),
    .o_out_upper_z(o_out_upper_z)
);

`default_nettype wire

FILE: verif/aabb_affine_transform_test.sv
// Self-checking bench for the affine box transform: directed and random boxes
// under several transforms, checked field by field against a local predictor.
// Depends on aabb_pkg and the aabb_affine_transform RTL.
`timescale 1ns / 1ps
`default_nettype none

module aabb_affine_transform_test;
    import aabb_pkg::*;

    localparam int CW = 32;
    localparam int KW = 16;
    localparam int KFRAC = KW - 4;
    localparam int DRAIN = 60;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic   valid;
        t_coord lx, ly, lz, ux, uy, uz, ax, ay, az;
    } t_box;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    t_box        req_box = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    t_box        res_box;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;

    logic [47:0] mat_row [3];
    t_coord      offs [3];

    t_box        expected_boxes [$];
    int          fail_count = 0;
    int          sent_count = 0;
    int          seen_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_recv = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    aabb_affine_transform u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(req_valid), .o_req_ready(req_ready),
        .i_box_valid(req_box.valid),
        .i_in_lower_x(req_box.lx), .i_in_lower_y(req_box.ly), .i_in_lower_z(req_box.lz),
        .i_in_upper_x(req_box.ux), .i_in_upper_y(req_box.uy), .i_in_upper_z(req_box.uz),
        .i_in_align_x(req_box.ax), .i_in_align_y(req_box.ay), .i_in_align_z(req_box.az),
        .o_res_valid(res_valid), .i_res_ready(res_ready),
        .o_out_valid(res_box.valid),
        .o_out_lower_x(res_box.lx), .o_out_lower_y(res_box.ly), .o_out_lower_z(res_box.lz),
        .o_out_upper_x(res_box.ux), .o_out_upper_y(res_box.uy), .o_out_upper_z(res_box.uz),
        .o_out_align_x(res_box.ax), .o_out_align_y(res_box.ay), .o_out_align_z(res_box.az),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    function automatic longint clip_mag(logic signed [127:0] v);
        logic signed [127:0] lim;
        lim = 128'sd1 <<< 56;
        if (v > lim) return longint'(lim);
        if (v < -lim) return -longint'(lim);
        return longint'(v);
    endfunction

    // Floor of a*b / 2^f with the magnitude clipped.
    function automatic longint scaled_mul(longint a, longint b, int f);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clip_mag(p >>> f);
    endfunction

    function automatic longint sat_coord(longint v);
        longint hi, lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint align_ratio(longint num, longint den);
        logic signed [127:0] q;
        q = (128'(num) <<< 16) / 128'(den);
        if (q > 128'sd4294967296) q = 128'sd4294967296;
        if (q < -128'sd4294967296) q = -128'sd4294967296;
        return sat_coord(longint'(q));
    endfunction

    function automatic t_box transform_box(t_box b);
        t_box   r;
        longint lo [3], up [3], al [3], ext [3], sum [3], org [3];
        longint ctr, nl, tor, m, p, lw, uw, na;
        r = b;
        if (!b.valid) return r;
        lo = '{b.lx, b.ly, b.lz};
        up = '{b.ux, b.uy, b.uz};
        al = '{b.ax, b.ay, b.az};
        for (int j = 0; j < 3; j++) begin
            ext[j] = up[j] - lo[j];
            sum[j] = up[j] + lo[j];
            org[j] = lo[j] + scaled_mul(al[j], ext[j], ALIGN_FRAC);
        end
        for (int i = 0; i < 3; i++) begin
            ctr = 2 * longint'(offs[i]);
            nl = 0;
            tor = offs[i];
            for (int j = 0; j < 3; j++) begin
                m = longint'($signed(mat_row[i][j*KW +: KW]));
                p = scaled_mul(m, ext[j], KFRAC);
                ctr += scaled_mul(m, sum[j], KFRAC);
                nl += p < 0 ? -p : p;
                tor += scaled_mul(m, org[j], KFRAC);
            end
            lw = (ctr - nl) >>> 1;
            uw = (ctr + nl) >>> 1;
            na = nl <= EXT_EPS ? al[i] : align_ratio(tor - lw, nl);
            case (i)
                0: begin
                    r.lx = t_coord'(sat_coord(lw));
                    r.ux = t_coord'(sat_coord(uw));
                    r.ax = t_coord'(na);
                end
                1: begin
                    r.ly = t_coord'(sat_coord(lw));
                    r.uy = t_coord'(sat_coord(uw));
                    r.ay = t_coord'(na);
                end
                default: begin
                    r.lz = t_coord'(sat_coord(lw));
                    r.uz = t_coord'(sat_coord(uw));
                    r.az = t_coord'(na);
                end
            endcase
        end
        return r;
    endfunction

    // The write beat stays offered until the next send or idle wait drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_ROW0: mat_row[0] = val;
            CFG_ROW1: mat_row[1] = val;
            CFG_ROW2: mat_row[2] = val;
            CFG_OFFX: offs[0] = val[CW-1:0];
            CFG_OFFY: offs[1] = val[CW-1:0];
            default: offs[2] = val[CW-1:0];
        endcase
    endtask

    task automatic send_box(t_box b);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_box <= b;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        expected_boxes.push_back(transform_box(b));
        sent_count++;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        req_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_boxes.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic t_coord pick_coord();
        case ($urandom_range(5))
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(2047)) - 1024) <<< 16;
            2: return t_coord'($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return t_coord'($signed($urandom_range(200000)) - 100000) <<< 4;
        endcase
    endfunction

    function automatic t_box random_box();
        t_box b;
        b.valid = $urandom_range(9) != 0;
        b.lx = pick_coord(); b.ly = pick_coord(); b.lz = pick_coord();
        b.ux = ($urandom_range(3) == 0) ? b.lx + t_coord'($urandom_range(6)) : pick_coord();
        b.uy = pick_coord(); b.uz = pick_coord();
        b.ax = ($urandom_range(1)) ? t_coord'($urandom_range(65536)) : t_coord'($urandom);
        b.ay = t_coord'($urandom_range(65536));
        b.az = ($urandom_range(3) == 0) ? t_coord'($urandom) : t_coord'($urandom_range(65536));
        return b;
    endfunction

    function automatic logic [47:0] random_row();
        logic [47:0] v;
        for (int j = 0; j < 3; j++) begin
            v[j*KW +: KW] = ($urandom_range(3) == 0) ? 16'($urandom)
                : 16'($signed($urandom_range(16384)) - 8192);
        end
        return v;
    endfunction

    task automatic test_directed_boxes();
        t_box b;
        b = '{1'b1, 0, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000, 32'sh8000, 0, 32'sh10000};
        send_box(b);
        b = '{1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0};
        send_box(b);
        b = '{1'b1, 32'sh50000, 5, -5, 32'sh50003, 5, -2, 32'sh12345, -3, 32'sh7fffffff};
        send_box(b);
        b = '{1'b1, 32'sh40000, 32'sh40000, 0, -32'sh40000, 0, -32'sh40000, 32'sh4000, 0, 1};
        send_box(b);
        b = '{1'b0, 32'sh7fffffff, 32'sh80000000, 32'shffffffff, 0, 32'sh5a5a5a5a,
              32'sha5a5a5a5, 1, -1, 32'sh80000000};
        send_box(b);
        b = '{1'b0, '1, '1, '1, '1, '1, '1, '1, '1, '1};
        send_box(b);
        b = '{1'b1, '1, '1, '1, 0, 0, 0, '1, '1, '1};
        send_box(b);
        wait_idle();
    endtask

    task automatic test_extreme_transforms();
        write_reg(CFG_ROW0, {16'h8000, 16'h8000, 16'h8000});
        write_reg(CFG_ROW1, {16'h7fff, 16'h7fff, 16'h7fff});
        write_reg(CFG_ROW2, 48'h0);
        write_reg(CFG_OFFX, 48'h7fffffff);
        write_reg(CFG_OFFY, 48'h80000000);
        write_reg(CFG_OFFZ, 48'hffffffff);
        repeat (10) send_box(random_box());
        send_box('{1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0});
        wait_idle();
    endtask

    task automatic test_random_boxes(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 0) begin
                wait_idle();
                for (int i = 0; i < 3; i++) write_reg(CFG_IDX_W'(i), random_row());
                for (int i = 3; i < 6; i++) write_reg(CFG_IDX_W'(i), 48'($urandom));
            end
            send_box(random_box());
        end
        wait_idle();
    endtask

    task automatic test_back_pressure();
        hold_recv = 1'b1;
        for (int k = 0; k < 80; k++) send_box(random_box());
        wait_idle();
    endtask

    initial begin
        mat_row = '{48'h1000, 48'h1000 << 16, 48'h1000 << 32};
        offs = '{0, 0, 0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 28;
        recv_idle_pct = 66;
        test_directed_boxes();
        test_extreme_transforms();
        test_random_boxes(150);
        send_idle_pct = 66;
        recv_idle_pct = 28;
        test_random_boxes(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_boxes(100);
        test_back_pressure();
        $display("Covered %0d boxes, %0d results checked, over directed and random transforms.",
                 sent_count, seen_count);
        if (fail_count == 0 && expected_boxes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_recv) begin
            res_ready <= 1'b0;
        end else begin
            res_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // Long receiver stall counted here, so the pipeline fills and input stalls.
    initial begin
        wait (hold_recv);
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
    end

    always @(posedge clk) begin
        t_box e;
        if (rst_n && res_valid && res_ready) begin
            seen_count++;
            if (expected_boxes.size() == 0) begin
                $error("result beat with no expectation pending");
                fail_count++;
            end else begin
                e = expected_boxes.pop_front();
                if (res_box !== e) begin
                    fail_count++;
                    if (res_box.valid !== e.valid)
                        $error("out_valid expected %0d got %0d", e.valid, res_box.valid);
                    if (res_box.lx !== e.lx) $error("out_lower_x expected %0d got %0d", e.lx, res_box.lx);
                    if (res_box.ly !== e.ly) $error("out_lower_y expected %0d got %0d", e.ly, res_box.ly);
                    if (res_box.lz !== e.lz) $error("out_lower_z expected %0d got %0d", e.lz, res_box.lz);
                    if (res_box.ux !== e.ux) $error("out_upper_x expected %0d got %0d", e.ux, res_box.ux);
                    if (res_box.uy !== e.uy) $error("out_upper_y expected %0d got %0d", e.uy, res_box.uy);
                    if (res_box.uz !== e.uz) $error("out_upper_z expected %0d got %0d", e.uz, res_box.uz);
                    if (res_box.ax !== e.ax) $error("out_align_x expected %0d got %0d", e.ax, res_box.ax);
                    if (res_box.ay !== e.ay) $error("out_align_y expected %0d got %0d", e.ay, res_box.ay);
                    if (res_box.az !== e.az) $error("out_align_z expected %0d got %0d", e.az, res_box.az);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: aabb_affine_transform.f
hdl/aabb_pkg.sv
hdl/aabb_affine_transform.sv
hdl/aabb_checker.sv
verif/aabb_affine_transform_test.sv
